>>> src/gof_pkg.sv
`default_nettype none
package gof_pkg;
   localparam int PIX_W          = 8;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int FW_W           = 11;
   localparam int FH_W           = 12;
   localparam int ROW_W          = 12;
   localparam int POS_W          = 16;
   localparam int FLOW_W         = 18;
   localparam int NUM_W          = 25;
   localparam int DEN_W          = 17;
   localparam int FLOW_SAT       = 131071;
   localparam int ROW_LIMIT      = 4095;
   localparam int FW_RESET       = 640;
   localparam int FH_RESET       = 480;
   localparam int CSR_AW         = 3;
   localparam logic [CSR_AW-1:0] REG_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_AW-1:0] REG_FRAME_HEIGHT = 3'd4;
endpackage
`default_nettype wire

>>> src/gof_ram.sv
`default_nettype none
module gof_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

>>> src/gof_div.sv
`default_nettype none
module gof_div
   import gof_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [DEN_W-1:0] denom,
   output logic                  busy,
   output logic      [NUM_W-1:0] quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         rem_in  = '0;
         quo_in  = numer;
         den_in  = denom;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quot = quo_ff;
endmodule
`default_nettype wire

>>> src/gradient_optical_flow.sv
// Gradient optical flow over a raster stream of pixel pairs.
// The req channel carries one transfer per pixel: current and previous frame
// intensity in tdata and a frame start flag in tuser. The rsp channel carries
// one transfer for each interior pixel: flow u and v in tdata, the flat
// gradient flag in tuser and the last interior result of a frame in tlast.
// A result belongs to the pixel one row and one column before the pixel that
// produced it; border pixels give no transfer.
// Frame width and height must be written through the csr port only while
// idle; the block itself does not enforce this. A pixel that gives no result
// passes through a line store read and a write back; a pixel that gives a
// result also passes a multiply stage and two restoring dividers in parallel.
// The result waits in an output register, so a stalled receiver only holds
// the block once a second result is ready. Reset clears the position
// counters, the window registers and the configuration to 640 by 480; the
// line stores are not cleared and are filled by the first rows of a frame.
`default_nettype none
module gradient_optical_flow
   import gof_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [15:0]       req_tdata,  // cur_pixel, prev_pixel
   input  wire logic              req_tuser,  // frame_start
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic      [39:0]       rsp_tdata,  // flow_u, flow_v, zero fill
   output logic                   rsp_tuser,  // flat_gradient
   output logic                   rsp_tlast,  // frame_end
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic      [31:0]       csr_prdata,
   output logic                   csr_pready
);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = 3 * PIX_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_START = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [FW_W-1:0]   fw_ff, fw_in;
   logic [FH_W-1:0]   fh_ff, fh_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [CW-1:0]     c_ff, c_in;
   logic [ROW_W-1:0]  r_ff, r_in;
   logic [PIX_W-1:0]  p_ff, p_in, q_ff, q_in;
   logic [PIX_W-1:0]  wl_ff, wl_in, wc_ff, wc_in, pc_ff, pc_in;
   logic signed [PIX_W:0] vd_ff, vd_in;
   logic signed [PIX_W:0] gx_ff, gx_in, gy_ff, gy_in, it_ff, it_in;
   logic              fend_ff, fend_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [NUM_W-1:0]  nu_ff, nu_in, nv_ff, nv_in;
   logic              negu_ff, negu_in, negv_ff, negv_in;
   logic              ov_ff, ov_in;
   logic [FLOW_W-1:0] ou_ff, ou_in, ovv_ff, ovv_in;
   logic              oflat_ff, oflat_in, olast_ff, olast_in;

   logic              accept, csr_wr;
   logic [CW-1:0]     rd_addr;
   logic [RW-1:0]     rd_data;
   logic              wr_en;
   logic [PIX_W-1:0]  up, md, pm;
   logic [POS_W-1:0]  w16, c16, r16, h16;
   logic              hit;
   logic [PIX_W-1:0]  agx, agy, ait;
   logic [2*PIX_W-1:0] pxx, pyy, pxt, pyt;
   logic              busy_u, busy_v;
   logic [NUM_W-1:0]  qu, qv;
   logic [FLOW_W-1:0] su, sv;
   logic              div_start;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign div_start  = (state_ff == S_START);

   assign rd_addr = req_tuser ? '0 : col_ff;
   assign wr_en   = (state_ff == S_READ);
   assign up = rd_data[PIX_W-1:0];
   assign md = rd_data[2*PIX_W-1:PIX_W];
   assign pm = rd_data[3*PIX_W-1:2*PIX_W];

   assign w16 = (POS_W'(fw_ff) < POS_W'(MAX_WIDTH)) ? POS_W'(fw_ff) : POS_W'(MAX_WIDTH);
   assign h16 = POS_W'(fh_ff);
   assign c16 = POS_W'(c_ff);
   assign r16 = POS_W'(r_ff);
   assign hit = (r16 >= POS_W'(2)) && (c16 >= POS_W'(2))
             && (r16 + 1'b1 <= h16) && (c16 + 1'b1 <= w16);

   assign agx = gx_ff[PIX_W] ? PIX_W'(-gx_ff) : gx_ff[PIX_W-1:0];
   assign agy = gy_ff[PIX_W] ? PIX_W'(-gy_ff) : gy_ff[PIX_W-1:0];
   assign ait = it_ff[PIX_W] ? PIX_W'(-it_ff) : it_ff[PIX_W-1:0];

   assign pxx = agx * agx;
   assign pyy = agy * agy;
   assign pxt = agx * ait;
   assign pyt = agy * ait;

   assign su = (qu > NUM_W'(FLOW_SAT)) ? FLOW_W'(FLOW_SAT) : qu[FLOW_W-1:0];
   assign sv = (qv > NUM_W'(FLOW_SAT)) ? FLOW_W'(FLOW_SAT) : qv[FLOW_W-1:0];

   gof_ram #(.WIDTH(RW), .DEPTH(MAX_WIDTH)) u_lines (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (c_ff),
      .wr_data ({q_ff, p_ff, md}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gof_div u_div_u (
      .clock (clock), .reset (reset), .start (div_start),
      .numer (nu_ff), .denom (den_ff), .busy (busy_u), .quot (qu)
   );

   gof_div u_div_v (
      .clock (clock), .reset (reset), .start (div_start),
      .numer (nv_ff), .denom (den_ff), .busy (busy_v), .quot (qv)
   );

   always_comb begin
      state_in = state_ff;
      fw_in = fw_ff;
      fh_in = fh_ff;
      col_in = col_ff;
      row_in = row_ff;
      c_in = c_ff;
      r_in = r_ff;
      p_in = p_ff;
      q_in = q_ff;
      wl_in = wl_ff;
      wc_in = wc_ff;
      pc_in = pc_ff;
      vd_in = vd_ff;
      gx_in = gx_ff;
      gy_in = gy_ff;
      it_in = it_ff;
      fend_in = fend_ff;
      den_in = den_ff;
      nu_in = nu_ff;
      nv_in = nv_ff;
      negu_in = negu_ff;
      negv_in = negv_ff;
      ov_in = ov_ff;
      ou_in = ou_ff;
      ovv_in = ovv_ff;
      oflat_in = oflat_ff;
      olast_in = olast_ff;

      if (csr_wr && csr_paddr == REG_FRAME_WIDTH) begin
         fw_in = csr_pwdata[FW_W-1:0];
      end
      if (csr_wr && csr_paddr == REG_FRAME_HEIGHT) begin
         fh_in = csr_pwdata[FH_W-1:0];
      end

      if (ov_ff && rsp_tready) begin
         ov_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               c_in = rd_addr;
               r_in = req_tuser ? '0 : row_ff;
               p_in = req_tdata[PIX_W-1:0];
               q_in = req_tdata[2*PIX_W-1:PIX_W];
               state_in = S_READ;
            end
         end
         S_READ: begin
            gx_in = $signed({1'b0, md}) - $signed({1'b0, wl_ff});
            gy_in = vd_ff;
            it_in = $signed({1'b0, wc_ff}) - $signed({1'b0, pc_ff});
            fend_in = (r16 + 1'b1 == h16) && (c16 + 1'b1 == w16);
            wl_in = wc_ff;
            wc_in = md;
            pc_in = pm;
            vd_in = $signed({1'b0, p_ff}) - $signed({1'b0, up});
            if (c16 + 1'b1 >= w16) begin
               col_in = '0;
               row_in = (r_ff < ROW_W'(ROW_LIMIT)) ? r_ff + 1'b1 : r_ff;
            end else begin
               col_in = c_ff + 1'b1;
               row_in = r_ff;
            end
            state_in = hit ? S_MUL : S_IDLE;
         end
         S_MUL: begin
            den_in  = DEN_W'(pxx) + DEN_W'(pyy);
            nu_in   = NUM_W'({pxt, 9'b0});
            nv_in   = NUM_W'({pyt, 9'b0});
            negu_in = (gx_ff[PIX_W] == it_ff[PIX_W]);
            negv_in = (gy_ff[PIX_W] == it_ff[PIX_W]);
            state_in = S_START;
         end
         S_START: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (!busy_u && !busy_v) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!ov_ff || rsp_tready) begin
               ov_in = 1'b1;
               oflat_in = (den_ff == '0);
               olast_in = fend_ff;
               if (den_ff == '0) begin
                  ou_in = '0;
                  ovv_in = '0;
               end else begin
                  ou_in = negu_ff ? FLOW_W'(-su) : su;
                  ovv_in = negv_ff ? FLOW_W'(-sv) : sv;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fw_ff <= FW_W'(FW_RESET);
         fh_ff <= FH_W'(FH_RESET);
         col_ff <= '0;
         row_ff <= '0;
         wl_ff <= '0;
         wc_ff <= '0;
         pc_ff <= '0;
         vd_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fw_ff <= fw_in;
         fh_ff <= fh_in;
         col_ff <= col_in;
         row_ff <= row_in;
         wl_ff <= wl_in;
         wc_ff <= wc_in;
         pc_ff <= pc_in;
         vd_ff <= vd_in;
         ov_ff <= ov_in;
      end
      c_ff <= c_in;
      r_ff <= r_in;
      p_ff <= p_in;
      q_ff <= q_in;
      gx_ff <= gx_in;
      gy_ff <= gy_in;
      it_ff <= it_in;
      fend_ff <= fend_in;
      den_ff <= den_in;
      nu_ff <= nu_in;
      nv_ff <= nv_in;
      negu_ff <= negu_in;
      negv_ff <= negv_in;
      ou_ff <= ou_in;
      ovv_ff <= ovv_in;
      oflat_ff <= oflat_in;
      olast_ff <= olast_in;
   end

   always_comb begin
      case (csr_paddr)
         REG_FRAME_WIDTH:  csr_prdata = 32'(fw_ff);
         REG_FRAME_HEIGHT: csr_prdata = 32'(fh_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {4'b0, ovv_ff, ou_ff};
   assign rsp_tuser  = oflat_ff;
   assign rsp_tlast  = olast_ff;

   a_flat_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[2*FLOW_W-1:0] == '0)
      else $error("flat gradient result carries nonzero flow");

   a_div_runs: assert property (@(posedge clock) disable iff (reset)
      div_start |=> busy_u && busy_v)
      else $error("dividers did not start");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      POS_W'(col_ff) < POS_W'(MAX_WIDTH))
      else $error("column counter out of range");

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready)
      else $error("input taken while an item is in flight");
endmodule
`default_nettype wire
